FILE: design/sorted_array_search_core_defines.svh
// ----------------------------------------------------------------------------
// sorted array search core assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_SEARCH_CORE_DEFINES_SVH
`define SORTED_ARRAY_SEARCH_CORE_DEFINES_SVH

// same-cycle implication
`define SAS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// Beat types, field widths and codes for the sorted array search core.
// ----------------------------------------------------------------------------
`default_nettype none

package sas_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int KEY_W      = 32;
  localparam int LOAD_IDX_W = 10;
  localparam int POS_W      = 10;
  localparam int COUNT_W    = 11;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // input kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // search modes, the spare code runs as binary search
  localparam logic [MODE_W-1:0] MODE_SEQ    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BIN    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_INTERP = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b1;

  localparam logic [MODE_W-1:0]  SEARCH_MODE_RST = MODE_BIN;
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = '0;

  typedef struct packed {
    logic                     kind;
    logic [LOAD_IDX_W-1:0]    load_index;
    logic signed [KEY_W-1:0]  entry_value;
    logic signed [KEY_W-1:0]  search_key;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

FILE: design/sorted_array_search_core.sv
// ----------------------------------------------------------------------------
// sorted_array_search_core
// Table of signed entries with sequential, binary and interpolation search.
// ----------------------------------------------------------------------------
// Load beats write one table entry. A search beat holds the input until its
// one result beat is built; every probe is one registered read of the
// table's single read port. Interpolation search spends most of each probe
// in the bit-serial divider, and skips it when the span is flat. The result
// sits in an output register, so a new beat may be taken while it waits.
// There is no clearing pass: entries are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_array_search_core_defines.svh"

module sorted_array_search_core #(
  parameter int TABLE_DEPTH = sas_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire sas_pkg::in_item_t                  in_data,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      sas_pkg::out_item_t                 out_data,
  input  wire logic                               cfg_write,
  input  wire logic [sas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sas_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int KEY_W   = sas_pkg::KEY_W;
  localparam int POS_W   = sas_pkg::POS_W;
  localparam int COUNT_W = sas_pkg::COUNT_W;
  localparam int MODE_W  = sas_pkg::MODE_W;
  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int LH_W    = IDX_W + 2;
  localparam int PROD_W  = KEY_W + IDX_W;

  localparam logic signed [LH_W-1:0] ONE_LH = 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LIN_RD,
    S_LIN_CMP,
    S_BIN_RD,
    S_BIN_CMP,
    S_INT_RDLO,
    S_INT_RDHI,
    S_INT_CHK,
    S_INT_MUL,
    S_INT_DSTART,
    S_INT_DIV,
    S_INT_PROBE,
    S_DONE
  } state_t;

  state_t state;

  logic [MODE_W-1:0]       search_mode;
  logic [COUNT_W-1:0]      entry_count;

  logic signed [KEY_W-1:0] key;
  logic [CNT_W-1:0]        n;
  logic [CNT_W-1:0]        i;
  logic signed [LH_W-1:0]  lo;
  logic signed [LH_W-1:0]  hi;
  logic [IDX_W-1:0]        mid;
  logic signed [KEY_W-1:0] alo;
  logic signed [KEY_W-1:0] ahi;
  logic [PROD_W-1:0]       prod;
  logic                    res_found;
  logic [POS_W-1:0]        res_pos;

  logic [CNT_W-1:0]        n_eff;
  logic signed [LH_W-1:0]  lh_sum;
  logic [IDX_W-1:0]        mid_bin;
  logic signed [LH_W-1:0]  mid_lh;
  logic [KEY_W:0]          key_diff;
  logic [KEY_W:0]          span_diff;
  logic [IDX_W-1:0]        span;

  logic                    in_beat;
  logic                    out_load;
  logic                    tbl_wr_en;
  logic [IDX_W-1:0]        tbl_wr_addr;
  logic                    tbl_rd_en;
  logic [IDX_W-1:0]        tbl_rd_addr;
  logic signed [KEY_W-1:0] rd_data;

  logic                    div_start;
  sas_pkg::div_status_t    div_st;
  logic [IDX_W-1:0]        div_q;

  assign in_ready = (state == S_IDLE);
  assign in_beat  = in_valid && in_ready;

  // result register takes a new beat when empty or draining this cycle
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // entries searched, capped at the table depth
  assign n_eff = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                       : CNT_W'(entry_count);

  assign lh_sum    = lo + hi;
  assign mid_bin   = lh_sum[IDX_W:1];
  assign mid_lh    = $signed(LH_W'(mid));
  assign key_diff  = {key[KEY_W-1], key} - {alo[KEY_W-1], alo};
  assign span_diff = {ahi[KEY_W-1], ahi} - {alo[KEY_W-1], alo};
  assign span      = IDX_W'(hi - lo);

  assign tbl_wr_en   = in_beat && (in_data.kind == sas_pkg::KIND_LOAD) &&
                       (32'(in_data.load_index) < 32'(TABLE_DEPTH));
  assign tbl_wr_addr = IDX_W'(in_data.load_index);

  always_comb begin
    tbl_rd_en   = 1'b1;
    tbl_rd_addr = mid;
    case (state)
      S_LIN_RD:    tbl_rd_addr = IDX_W'(i);
      S_BIN_RD:    tbl_rd_addr = mid_bin;
      S_INT_RDLO:  tbl_rd_addr = IDX_W'(lo);
      S_INT_RDHI:  tbl_rd_addr = IDX_W'(hi);
      S_INT_CHK:   tbl_rd_addr = IDX_W'(lo);
      S_INT_PROBE: tbl_rd_addr = mid;
      default:     tbl_rd_en   = 1'b0;
    endcase
  end

  assign div_start = (state == S_INT_DSTART);

  sas_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (in_data.entry_value),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (rd_data)
  );

  sas_div #(
    .Q_W (IDX_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (span_diff[KEY_W-1:0]),
    .status   (div_st),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      search_mode <= sas_pkg::SEARCH_MODE_RST;
      entry_count <= sas_pkg::ENTRY_COUNT_RST;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sas_pkg::REG_SEARCH_MODE: search_mode <= cfg_data[MODE_W-1:0];
          sas_pkg::REG_ENTRY_COUNT: entry_count <= cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_beat && (in_data.kind == sas_pkg::KIND_SEARCH)) begin
            key <= in_data.search_key;
            n   <= n_eff;
            i   <= '0;
            lo  <= '0;
            hi  <= $signed(LH_W'(n_eff)) - ONE_LH;
            case (search_mode)
              sas_pkg::MODE_SEQ:    state <= S_LIN_RD;
              sas_pkg::MODE_INTERP: state <= S_INT_RDLO;
              default:              state <= S_BIN_RD;
            endcase
          end
        end

        S_LIN_RD: begin
          if (i >= n) begin
            res_found <= 1'b0;
            res_pos   <= '0;
            state     <= S_DONE;
          end else begin
            state <= S_LIN_CMP;
          end
        end

        S_LIN_CMP: begin
          if (rd_data == key) begin
            res_found <= 1'b1;
            res_pos   <= POS_W'(i);
            state     <= S_DONE;
          end else begin
            i     <= i + CNT_W'(1);
            state <= S_LIN_RD;
          end
        end

        S_BIN_RD: begin
          if (hi < lo) begin
            res_found <= 1'b0;
            res_pos   <= '0;
            state     <= S_DONE;
          end else begin
            mid   <= mid_bin;
            state <= S_BIN_CMP;
          end
        end

        // shared probe compare for binary and interpolation search
        S_BIN_CMP: begin
          if (rd_data == key) begin
            res_found <= 1'b1;
            res_pos   <= POS_W'(mid);
            state     <= S_DONE;
          end else begin
            if (rd_data > key) begin
              hi <= mid_lh - ONE_LH;
            end else begin
              lo <= mid_lh + ONE_LH;
            end
            state <= (search_mode == sas_pkg::MODE_INTERP) ? S_INT_RDLO : S_BIN_RD;
          end
        end

        S_INT_RDLO: begin
          if (hi < lo) begin
            res_found <= 1'b0;
            res_pos   <= '0;
            state     <= S_DONE;
          end else begin
            state <= S_INT_RDHI;
          end
        end

        S_INT_RDHI: begin
          alo   <= rd_data;
          state <= S_INT_CHK;
        end

        S_INT_CHK: begin
          ahi <= rd_data;
          if ((key < alo) || (key > rd_data)) begin
            res_found <= 1'b0;
            res_pos   <= '0;
            state     <= S_DONE;
          end else if (rd_data == alo) begin
            // flat span: probe the low end, read issued this cycle
            mid   <= IDX_W'(lo);
            state <= S_BIN_CMP;
          end else begin
            state <= S_INT_MUL;
          end
        end

        S_INT_MUL: begin
          prod  <= PROD_W'(key_diff[KEY_W-1:0] * span);
          state <= S_INT_DSTART;
        end

        S_INT_DSTART: begin
          state <= S_INT_DIV;
        end

        S_INT_DIV: begin
          if (div_st.done) begin
            mid   <= IDX_W'(lo + $signed(LH_W'(div_q)));
            state <= S_INT_PROBE;
          end
        end

        S_INT_PROBE: begin
          state <= S_BIN_CMP;
        end

        S_DONE: begin
          if (out_load) begin
            out_data.found    <= res_found;
            out_data.position <= res_pos;
            state             <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `SAS_ASSERT_IMP(a_idle_div_quiet, in_ready, !div_st.busy, "divider busy while idle")
  `SAS_ASSERT_IMP(a_div_done_owner, div_st.done, state == S_INT_DIV, "stray divider done")
  `SAS_ASSERT_IMP(a_probe_in_span, state == S_BIN_CMP, (lo <= mid_lh) && (mid_lh <= hi), "probe off span")
  `SAS_ASSERT_NXT(a_done_delivers, out_load, out_valid && (state == S_IDLE), "result not delivered")

endmodule

`default_nettype wire

FILE: design/sas_table.sv
// ----------------------------------------------------------------------------
// sas_table
// Single write, single registered read table memory holding the entries.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_table #(
  parameter int DEPTH = sas_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
  input  wire logic [sas_pkg::KEY_W-1:0]     wr_data,
  input  wire logic                          rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
  output      logic [sas_pkg::KEY_W-1:0]     rd_data
);

  logic [sas_pkg::KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/sas_div.sv
// ----------------------------------------------------------------------------
// sas_div
// Restoring divider, one quotient bit per cycle, for the interpolation probe.
// The caller guarantees the quotient fits in Q_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sas_div #(
  parameter int Q_W = 10
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic [sas_pkg::KEY_W+Q_W-1:0]    dividend,
  input  wire logic [sas_pkg::KEY_W-1:0]        divisor,
  output      sas_pkg::div_status_t             status,
  output      logic [Q_W-1:0]                   quotient
);

  localparam int KEY_W = sas_pkg::KEY_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt;
  logic             done;
  logic [KEY_W-1:0] rem;
  logic [Q_W-1:0]   low;
  logic [KEY_W-1:0] dsr;
  logic [KEY_W:0]   trial;
  logic             q_bit;

  // shift in the next dividend bit and try the subtract
  assign trial = {rem, low[Q_W-1]} - {1'b0, dsr};
  assign q_bit = ~trial[KEY_W] | rem[KEY_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= dividend[KEY_W+Q_W-1:Q_W];
        low <= dividend[Q_W-1:0];
        dsr <= divisor;
        cnt <= CNT_W'(Q_W);
      end else if (cnt != '0) begin
        if (q_bit) begin
          rem <= trial[KEY_W-1:0];
        end else begin
          rem <= {rem[KEY_W-2:0], low[Q_W-1]};
        end
        low      <= low << 1;
        quotient <= Q_W'({quotient, q_bit});
        cnt      <= cnt - CNT_W'(1);
        done     <= (cnt == CNT_W'(1));
      end
    end
  end

  assign status.busy = (cnt != '0);
  assign status.done = done;

endmodule

`default_nettype wire
